FILE: rtl/assert_macros.svh
// assertion macros used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define MCR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define MCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: rtl/mcr_pkg.sv
// shared types, constants and control bundles of the midpoint circle rasterizer
`default_nettype none

package mcr_pkg;

   localparam int COORD_BITS  = 10;
   localparam int RADIUS_BITS = 9;
   localparam int PIX_BITS    = COORD_BITS + 2;
   localparam int DEC_BITS    = RADIUS_BITS + 3;

   // sqrt(1/2) with 16 fraction bits
   localparam int          SQRT_FRAC_BITS = 16;
   localparam logic [15:0] SQRT_HALF_Q16  = 16'd46341;

   localparam int STEP_PIXELS   = 8;
   localparam int FINISH_PIXELS = 5;
   localparam int PIX_IDX_BITS  = 3;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic {
      COLOR_WHITE = 1'b0,
      COLOR_RED   = 1'b1
   } color_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_STEP_OUT,
      ST_FINISH_OUT
   } state_type;

   typedef struct packed {
      logic                   operation;
      logic [COORD_BITS-1:0]  center_x;
      logic [COORD_BITS-1:0]  center_y;
      logic [RADIUS_BITS-1:0] radius;
   } req_word_type;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] pixel_x;
      logic signed [PIX_BITS-1:0] pixel_y;
      logic                       color;
      logic                       last_of_run;
      logic                       circle_done;
   } rsp_word_type;

   typedef struct packed {
      logic                    load;
      logic                    step;
      logic                    emit;
      logic                    finish;
      logic [PIX_IDX_BITS-1:0] pix_sel;
      logic                    last;
      logic                    done;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic rsp_room;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/mcr_datapath.sv
// circle walk registers, pixel generation and the result word register
`default_nettype none

module mcr_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  mcr_pkg::req_word_type req_word,
   input  mcr_pkg::cmd_type     cmd,
   output mcr_pkg::sts_type     sts,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mcr_pkg::rsp_word_type rsp_word
);

   localparam int RB = mcr_pkg::RADIUS_BITS;
   localparam int PB = mcr_pkg::PIX_BITS;
   localparam int DB = mcr_pkg::DEC_BITS;
   localparam int MB = RB + mcr_pkg::SQRT_FRAC_BITS;

   logic [mcr_pkg::COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RB-1:0]                  rad_ff, rad_in, x_ff, x_in, y_ff, y_in;
   logic [RB-1:0]                  left_ff, left_in;
   logic [DB-1:0]                  dec_ff, dec_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mcr_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [MB-1:0] oct_prod;
   logic [RB-1:0] x_inc, y_dec;
   logic [PB-1:0] cxw, cyw, xw, yw, rw;
   logic [PB-1:0] px, py;

   // walk registers
   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      rad_in  = rad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      dec_in  = dec_ff;
      left_in = left_ff;
      oct_prod = MB'(req_word.radius) * MB'(mcr_pkg::SQRT_HALF_Q16);
      x_inc   = x_ff + RB'(1);
      y_dec   = y_ff - RB'(1);
      if (cmd.load) begin
         cx_in   = req_word.center_x;
         cy_in   = req_word.center_y;
         rad_in  = req_word.radius;
         x_in    = '0;
         y_in    = req_word.radius;
         dec_in  = DB'(1) - DB'(req_word.radius);
         left_in = oct_prod[MB-1:mcr_pkg::SQRT_FRAC_BITS];
      end else if (cmd.step) begin
         x_in    = x_inc;
         left_in = left_ff - RB'(1);
         if (!dec_ff[DB-1]) begin
            // decision >= 0: move diagonally
            y_in   = y_dec;
            dec_in = dec_ff + DB'({x_inc, 1'b1}) - DB'({y_dec, 1'b0});
         end else begin
            dec_in = dec_ff + DB'({x_inc, 1'b1});
         end
      end
   end

   // pixel selection
   always_comb begin
      cxw = PB'(cx_ff);
      cyw = PB'(cy_ff);
      xw  = PB'(x_ff);
      yw  = PB'(y_ff);
      rw  = PB'(rad_ff);
      px  = cxw;
      py  = cyw;
      if (cmd.finish) begin
         case (cmd.pix_sel)
            3'd1:    begin px = cxw;      py = cyw + rw; end
            3'd2:    begin px = cxw;      py = cyw - rw; end
            3'd3:    begin px = cxw + rw; py = cyw;      end
            3'd4:    begin px = cxw - rw; py = cyw;      end
            default: begin px = cxw;      py = cyw;      end
         endcase
      end else begin
         case (cmd.pix_sel)
            3'd0:    begin px = cxw + xw; py = cyw + yw; end
            3'd1:    begin px = cxw - xw; py = cyw + yw; end
            3'd2:    begin px = cxw + xw; py = cyw - yw; end
            3'd3:    begin px = cxw - xw; py = cyw - yw; end
            3'd4:    begin px = cxw + yw; py = cyw + xw; end
            3'd5:    begin px = cxw - yw; py = cyw + xw; end
            3'd6:    begin px = cxw + yw; py = cyw - xw; end
            default: begin px = cxw - yw; py = cyw - xw; end
         endcase
      end
   end

   // result word register
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (cmd.emit) begin
         rsp_word_in.pixel_x     = px;
         rsp_word_in.pixel_y     = py;
         rsp_word_in.color       = (cmd.finish && cmd.pix_sel == '0) ?
                                   mcr_pkg::COLOR_RED : mcr_pkg::COLOR_WHITE;
         rsp_word_in.last_of_run = cmd.last;
         rsp_word_in.circle_done = cmd.done;
      end
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         rad_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         dec_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rad_ff       <= rad_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         dec_ff       <= dec_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign sts.steps_zero = (left_ff == '0);
   assign sts.rsp_room   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word       = rsp_word_ff;

endmodule

`default_nettype wire

FILE: rtl/mcr_control.sv
// controller state machine: item acceptance and pixel sequencing
`default_nettype none
`include "assert_macros.svh"

module mcr_control (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  mcr_pkg::req_word_type req_word,
   input  mcr_pkg::sts_type      sts,
   output mcr_pkg::cmd_type      cmd
);

   localparam int IB = mcr_pkg::PIX_IDX_BITS;

   mcr_pkg::state_type state_ff, state_in;
   logic [IB-1:0]      cnt_ff, cnt_in;
   logic               open, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcr_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      open     = (state_ff == mcr_pkg::ST_IDLE) || (state_ff == mcr_pkg::ST_WAIT);
      accept   = open && req_valid;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.pix_sel = cnt_ff;
      case (state_ff)
         mcr_pkg::ST_IDLE, mcr_pkg::ST_WAIT: begin
            if (accept) begin
               if (req_word.operation == mcr_pkg::OP_START) begin
                  cmd.load = 1'b1;
                  state_in = mcr_pkg::ST_WAIT;
               end else if (state_ff == mcr_pkg::ST_WAIT) begin
                  cnt_in = '0;
                  if (sts.steps_zero) begin
                     state_in = mcr_pkg::ST_FINISH_OUT;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = mcr_pkg::ST_STEP_OUT;
                  end
               end
            end
         end
         mcr_pkg::ST_STEP_OUT: begin
            if (sts.rsp_room) begin
               cmd.emit = 1'b1;
               cmd.last = (cnt_ff == IB'(mcr_pkg::STEP_PIXELS - 1));
               cnt_in   = cnt_ff + IB'(1);
               if (cmd.last) begin
                  state_in = mcr_pkg::ST_WAIT;
               end
            end
         end
         mcr_pkg::ST_FINISH_OUT: begin
            cmd.finish = 1'b1;
            if (sts.rsp_room) begin
               cmd.emit = 1'b1;
               cmd.last = (cnt_ff == IB'(mcr_pkg::FINISH_PIXELS - 1));
               cmd.done = cmd.last;
               cnt_in   = cnt_ff + IB'(1);
               if (cmd.last) begin
                  state_in = mcr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mcr_pkg::ST_IDLE;
         end
      endcase
      req_stall = !open;
   end

   `MCR_ASSERT_IMPLY(a_emit_room, cmd.emit, sts.rsp_room)
   `MCR_ASSERT_NEXT(a_step_emits, cmd.step, state_ff == mcr_pkg::ST_STEP_OUT && cnt_ff == '0)
   `MCR_ASSERT_IMPLY(a_finish_cnt, state_ff == mcr_pkg::ST_FINISH_OUT, cnt_ff <= IB'(mcr_pkg::FINISH_PIXELS - 1))

endmodule

`default_nettype wire

FILE: rtl/midpoint_circle_rasterizer.sv
// top level of the midpoint circle rasterizer: controller plus datapath
`default_nettype none

// midpoint circle rasterizer. a start word latches centre and radius, sets
// decision = 1 - r, x = 0, y = r and the octant step count floor(r*46341/65536)
// and produces no output. each advance word then takes one midpoint step and
// sends eight white outline pixels; once the count is spent the next advance
// sends the red centre and the four axis points, flags the last one as circle
// done and goes idle. an advance while idle is dropped. an advance word is
// accepted first; its pixels then go out one per cycle through the single
// result word register while rsp_stall stays low. a new word is taken as soon
// as the last pixel sits in the result register.
module midpoint_circle_rasterizer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  mcr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output mcr_pkg::rsp_word_type rsp_word
);

   // command and status bundles between controller and datapath
   mcr_pkg::cmd_type cmd;
   mcr_pkg::sts_type sts;

   // controller: accepts words, sequences the eight or five pixels
   mcr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: walk registers, octant count multiply, pixel adders, output word
   mcr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
